// ===== hdl/sorted_priority_queue_unit_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the sorted priority queue unit.
// The including module must provide aclk and aresetn.
// ----------------------------------------------------------------------------
`ifndef SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH
`define SORTED_PRIORITY_QUEUE_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SPQ_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define SPQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/spq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg
// Shared widths, command codes, status codes and the cell control struct.
// ----------------------------------------------------------------------------
package spq_pkg;

    localparam int DATA_W = 32;
    localparam int PRIO_W = 16;
    localparam int OCC_W  = 4;

    localparam logic CMD_ENQ = 1'b0;
    localparam logic CMD_DEQ = 1'b1;

    typedef enum logic [1:0] {
        ST_ENQUEUED  = 2'd0,
        ST_DEQUEUED  = 2'd1,
        ST_OVERFLOW  = 2'd2,
        ST_UNDERFLOW = 2'd3
    } spq_status_t;

    // Per-cycle strobes broadcast to every cell.
    typedef struct packed {
        logic enq;
        logic deq;
    } spq_ctrl_t;

endpackage

// ===== hdl/spq_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds an entry and moves it to a neighbor.
// ----------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
(
    input  logic              aclk,
    input  spq_ctrl_t         ctrl,
    input  logic              occupied,
    input  logic [DATA_W-1:0] new_data,
    input  logic [PRIO_W-1:0] new_prio,
    input  logic              prev_after,
    input  logic [DATA_W-1:0] prev_data,
    input  logic [PRIO_W-1:0] prev_prio,
    input  logic [DATA_W-1:0] next_data,
    input  logic [PRIO_W-1:0] next_prio,
    output logic              after,
    output logic [DATA_W-1:0] data,
    output logic [PRIO_W-1:0] prio
);

    logic [DATA_W-1:0] data_reg;
    logic [PRIO_W-1:0] prio_reg;

    // The new entry goes behind this one when it holds an equal or better priority.
    assign after = occupied && ($signed(prio_reg) <= $signed(new_prio));
    assign data  = data_reg;
    assign prio  = prio_reg;

    always_ff @(posedge aclk) begin
        if (ctrl.enq && !after) begin
            if (prev_after) begin
                data_reg <= new_data;
                prio_reg <= new_prio;
            end else begin
                data_reg <= prev_data;
                prio_reg <= prev_prio;
            end
        end else if (ctrl.deq) begin
            data_reg <= next_data;
            prio_reg <= next_prio;
        end
    end

endmodule

// ===== hdl/sorted_priority_queue_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_priority_queue_unit
// Min priority queue kept sorted in a chain of cells, one word per cycle while m_tready is high.
// ----------------------------------------------------------------------------
// Usage: each input word on the s_ channel is one command. s_tuser selects
// enqueue or dequeue; s_tdata carries the data and priority of a new entry.
// Every accepted word produces exactly one result word on the m_ channel
// with a status code in m_tuser and the dequeued entry plus the occupancy
// in m_tdata. Lower priority values leave first; equal priorities leave in
// arrival order.
// Timing: the result is registered and appears in the cycle after acceptance.
// Throughput: one command per cycle while m_tready is high. All cells
// compare against the new priority in parallel and shift in the same cycle,
// so the chain updates once per clock regardless of where the entry lands.
// Reset: aresetn clears the occupancy and the result valid flag; the queue
// is empty afterwards and can take a command as soon as reset is released.
// Stalls: the result register holds its word while m_tready is low, and
// s_tready drops until that word leaves; it rises in the same cycle the
// receiver takes the word, so no bubble is added.
// ----------------------------------------------------------------------------
module sorted_priority_queue_unit
    import spq_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic        aclk,
    input  logic        aresetn,
    // Input words.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // [31:0] in_data, [47:32] in_priority
    input  logic [0:0]  s_tuser,   // [0] cmd
    // Result words.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // [31:0] out_data, [47:32] out_priority,
                                   // [51:48] occupancy, [55:52] zero
    output logic [1:0]  m_tuser    // [1:0] status
);

    `include "sorted_priority_queue_unit_macros.svh"

    localparam int CW = $clog2(DEPTH + 1);

    // Unpacked input word.
    logic              cmd;
    logic [DATA_W-1:0] in_data;
    logic [PRIO_W-1:0] in_prio;

    assign cmd     = s_tuser[0];
    assign in_data = s_tdata[DATA_W-1:0];
    assign in_prio = s_tdata[DATA_W+PRIO_W-1:DATA_W];

    // Control state.
    logic [CW-1:0] count_reg, count_next;
    logic          m_valid_reg;

    // Result payload register.
    logic [55:0] m_tdata_reg, m_tdata_next;
    logic [1:0]  m_tuser_reg, m_tuser_next;

    logic accept;
    logic full;
    logic empty;
    spq_ctrl_t ctrl;

    assign s_tready = !m_valid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign full     = (count_reg == CW'(DEPTH));
    assign empty    = (count_reg == '0);

    assign ctrl.enq = accept && (cmd == CMD_ENQ) && !full;
    assign ctrl.deq = accept && (cmd == CMD_DEQ) && !empty;

    // Cell chain. Cell 0 is the front of the queue.
    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic [PRIO_W-1:0] cell_prio  [DEPTH];
    logic              cell_after [DEPTH];

    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        logic              prev_after;
        logic [DATA_W-1:0] prev_data;
        logic [PRIO_W-1:0] prev_prio;
        logic [DATA_W-1:0] next_data;
        logic [PRIO_W-1:0] next_prio;
        logic              occupied;

        // A slot is live when its index is below the entry count.
        assign occupied = (count_reg > CW'(i));

        if (i == 0) begin : g_front
            assign prev_after = 1'b1;
            assign prev_data  = in_data;
            assign prev_prio  = in_prio;
        end else begin : g_body
            assign prev_after = cell_after[i-1];
            assign prev_data  = cell_data[i-1];
            assign prev_prio  = cell_prio[i-1];
        end

        if (i == DEPTH - 1) begin : g_tail
            assign next_data = cell_data[i];
            assign next_prio = cell_prio[i];
        end else begin : g_inner
            assign next_data = cell_data[i+1];
            assign next_prio = cell_prio[i+1];
        end

        spq_cell u_cell (
            .aclk       (aclk),
            .ctrl       (ctrl),
            .occupied   (occupied),
            .new_data   (in_data),
            .new_prio   (in_prio),
            .prev_after (prev_after),
            .prev_data  (prev_data),
            .prev_prio  (prev_prio),
            .next_data  (next_data),
            .next_prio  (next_prio),
            .after      (cell_after[i]),
            .data       (cell_data[i]),
            .prio       (cell_prio[i])
        );
    end

    // Next count and the result word for the command being accepted.
    always_comb begin
        logic [DATA_W-1:0] r_data;
        logic [PRIO_W-1:0] r_prio;
        spq_status_t       r_status;

        count_next = count_reg;
        r_data     = '0;
        r_prio     = '0;
        r_status   = ST_ENQUEUED;

        if (cmd == CMD_ENQ) begin
            if (full) begin
                r_status = ST_OVERFLOW;
            end else begin
                r_status   = ST_ENQUEUED;
                count_next = count_reg + CW'(1);
            end
        end else begin
            if (empty) begin
                // Underflow reports all ones in both fields.
                r_status = ST_UNDERFLOW;
                r_data   = '1;
                r_prio   = '1;
            end else begin
                r_status   = ST_DEQUEUED;
                r_data     = cell_data[0];
                r_prio     = cell_prio[0];
                count_next = count_reg - CW'(1);
            end
        end

        m_tdata_next = {4'b0000, OCC_W'(count_next), r_prio, r_data};
        m_tuser_next = r_status;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            if (accept) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
            m_tuser_reg <= m_tuser_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // The entry count never exceeds the number of cells.
    `SPQ_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(DEPTH), "count above depth")

    // A rejected enqueue leaves the queue as it was.
    `SPQ_ASSERT_NEXT(a_overflow_keeps, accept && (cmd == CMD_ENQ) && full,
                     (count_reg == $past(count_reg)) && (m_tuser == ST_OVERFLOW),
                     "overflow changed the queue")

    // A dequeue on an empty queue reports underflow with all-ones payload.
    `SPQ_ASSERT_NEXT(a_underflow_word, accept && (cmd == CMD_DEQ) && empty,
                     (m_tuser == ST_UNDERFLOW) && (m_tdata[47:0] == '1),
                     "bad underflow word")

    // The count only moves when a command is accepted.
    `SPQ_ASSERT_NEXT(a_count_idle, !accept, count_reg == $past(count_reg),
                     "count moved without a command")

    // The reported occupancy matches the count left behind.
    `SPQ_ASSERT_SAME(a_occ_match, m_tvalid, m_tdata[51:48] == OCC_W'(count_reg),
                     "occupancy mismatch")

endmodule
